/* hdl/fvh_pkg.sv */
// Shared types, widths and constants of the formation velocity and heading block.
`timescale 1ns / 1ps
package fvh_pkg;

  localparam int POS_W   = 16;
  localparam int GAIN_W  = 8;
  localparam int CNT_W   = 2;
  localparam int SPD_W   = 15;
  localparam int HEAD_W  = 16;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;
  localparam int SUM_W   = 19;
  localparam int XY_W    = 30;
  localparam int Z_W     = 34;
  localparam int INV_K_W = 30;
  localparam int PROD_W  = (XY_W - 1) + INV_K_W;
  localparam int ATAN_LEN = 24;

  // Reciprocal of the converged rotation gain, scaled by 2^30.
  localparam logic [INV_K_W-1:0] INV_K = 30'd652032874;

  // Half a turn in angle units where 2^32 is a full turn.
  localparam logic signed [Z_W-1:0] Z_HALF_TURN = 34'sh080000000;

  localparam logic signed [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
    34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
    34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
    34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
    34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
    34'sd652,       34'sd326,       34'sd163,       34'sd81
  };

  typedef enum logic [IDX_W-1:0] {
    REG_NEIGHBOR_COUNT = 3'd0,
    REG_GAIN           = 3'd1,
    REG_OFFSET_X1      = 3'd2,
    REG_OFFSET_Y1      = 3'd3,
    REG_OFFSET_X2      = 3'd4,
    REG_OFFSET_Y2      = 3'd5,
    REG_DEAD_ZONE      = 3'd6,
    REG_SPEED_LIMIT    = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]         neighbor_count;
    logic [GAIN_W-1:0]        gain;
    logic signed [POS_W-1:0]  offset_x1;
    logic signed [POS_W-1:0]  offset_y1;
    logic signed [POS_W-1:0]  offset_x2;
    logic signed [POS_W-1:0]  offset_y2;
    logic [SPD_W-1:0]         dead_zone;
    logic [SPD_W-1:0]         speed_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] own_x;
    logic signed [POS_W-1:0] own_y;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic                    start_flag;
  } pos_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   zero;
    logic                   start;
  } rot_t;

  typedef struct packed {
    logic              drive_enable;
    logic [SPD_W-1:0]  speed;
    logic [HEAD_W-1:0] heading;
  } cmd_t;

  function automatic logic signed [SUM_W-1:0] ext_sum(input logic signed [POS_W-1:0] v);
    return SUM_W'(v);
  endfunction

endpackage

/* hdl/fvh_vector.sv */
// Neighbour error summation, gain scaling and half-plane pre-rotation, two register stages.
`timescale 1ns / 1ps
module fvh_vector #(
  parameter int MAX_NEIGHBORS = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fvh_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  fvh_pkg::pos_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fvh_pkg::rot_t out_data
);
  import fvh_pkg::*;

  logic                    a_valid_r;
  logic signed [SUM_W-1:0] a_sumx_r;
  logic signed [SUM_W-1:0] a_sumy_r;
  logic                    a_start_r;
  logic                    b_valid_r;
  rot_t                    b_data_r;
  logic                    a_ready;
  logic                    b_ready;

  logic                    use1;
  logic                    use2;
  logic signed [SUM_W-1:0] d1x, d1y, d2x, d2y;
  logic signed [SUM_W-1:0] sumx_nxt, sumy_nxt;
  logic signed [XY_W-1:0]  sx_e, sy_e, gain_e, px, py;
  rot_t                    b_data_nxt;

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  // Neighbour count saturates at the number of neighbour ports in use.
  assign use1 = (cfg.neighbor_count != '0);
  assign use2 = (MAX_NEIGHBORS >= 2) && (cfg.neighbor_count >= CNT_W'(2));

  always_comb begin
    d1x = ext_sum(in_data.first_x) - ext_sum(in_data.own_x) + ext_sum(cfg.offset_x1);
    d1y = ext_sum(in_data.first_y) - ext_sum(in_data.own_y) + ext_sum(cfg.offset_y1);
    d2x = ext_sum(in_data.second_x) - ext_sum(in_data.own_x) + ext_sum(cfg.offset_x2);
    d2y = ext_sum(in_data.second_y) - ext_sum(in_data.own_y) + ext_sum(cfg.offset_y2);
    sumx_nxt = (use1 ? d1x : '0) + (use2 ? d2x : '0);
    sumy_nxt = (use1 ? d1y : '0) + (use2 ? d2y : '0);
  end

  always_comb begin
    sx_e   = XY_W'(a_sumx_r);
    sy_e   = XY_W'(a_sumy_r);
    gain_e = $signed({{(XY_W - GAIN_W){1'b0}}, cfg.gain});
    px     = sx_e * gain_e;
    py     = sy_e * gain_e;
    b_data_nxt.zero  = (px == '0) && (py == '0);
    b_data_nxt.start = a_start_r;
    if (px < 0) begin
      b_data_nxt.x = -px;
      b_data_nxt.y = -py;
      b_data_nxt.z = (py >= 0) ? Z_HALF_TURN : -Z_HALF_TURN;
    end else begin
      b_data_nxt.x = px;
      b_data_nxt.y = py;
      b_data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_sumx_r  <= sumx_nxt;
      a_sumy_r  <= sumy_nxt;
      a_start_r <= in_data.start_flag;
    end
    if (b_ready && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign out_valid = b_valid_r;
  assign out_data  = b_data_r;

endmodule

/* hdl/fvh_cordic.sv */
// Vectoring rotation pipeline, one register stage per micro-rotation.
`timescale 1ns / 1ps
module fvh_cordic #(
  parameter int STAGES = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fvh_pkg::rot_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fvh_pkg::rot_t out_data
);
  import fvh_pkg::*;

  rot_t            st_r [STAGES];
  logic [STAGES-1:0] v_r;
  wire  [STAGES-1:0] rdy;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    rot_t prev;
    logic prev_v;
    rot_t nxt;
    logic signed [XY_W-1:0] xs, ys;

    if (i == 0) begin : g_first
      assign prev   = in_data;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev   = st_r[i-1];
      assign prev_v = v_r[i-1];
    end

    if (i == STAGES - 1) begin : g_last
      assign rdy[i] = !v_r[i] || out_ready;
    end else begin : g_mid
      assign rdy[i] = !v_r[i] || rdy[i+1];
    end

    // Shifts are arithmetic, so they round towards minus infinity.
    assign xs = prev.x >>> i;
    assign ys = prev.y >>> i;

    always_comb begin
      nxt = prev;
      if (prev.y > 0) begin
        nxt.x = prev.x + ys;
        nxt.y = prev.y - xs;
        nxt.z = prev.z + ATAN_TAB[i];
      end else begin
        nxt.x = prev.x - ys;
        nxt.y = prev.y + xs;
        nxt.z = prev.z - ATAN_TAB[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && prev_v) begin
        st_r[i] <= nxt;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[STAGES-1];
  assign out_data  = st_r[STAGES-1];

endmodule

/* hdl/fvh_scale.sv */
// Gain correction, rounding, dead zone and clamp, heading rounding; ends in the output register.
`timescale 1ns / 1ps
module fvh_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  fvh_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  fvh_pkg::rot_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output fvh_pkg::cmd_t out_data
);
  import fvh_pkg::*;

  localparam int SHIFT = 38;
  localparam int RAW_W = PROD_W + 1 - SHIFT;

  logic              m_valid_r;
  logic [PROD_W-1:0] m_prod_r;
  logic [HEAD_W-1:0] m_head_r;
  logic              m_zero_r;
  logic              m_start_r;
  logic              f_valid_r;
  cmd_t              f_data_r;
  logic              m_ready;
  logic              f_ready;

  logic [XY_W-2:0]   x_pos;
  logic [PROD_W-1:0] prod_nxt;
  logic [Z_W-1:0]    z_round;
  logic [PROD_W:0]   rnd_sum;
  logic [RAW_W-1:0]  spd_raw;
  logic [SPD_W-1:0]  spd_sat;
  cmd_t              f_data_nxt;

  assign f_ready  = !f_valid_r || out_ready;
  assign m_ready  = !m_valid_r || f_ready;
  assign in_ready = m_ready;

  always_comb begin
    x_pos    = (in_data.x < 0) ? '0 : in_data.x[XY_W-2:0];
    prod_nxt = PROD_W'(x_pos) * PROD_W'(INV_K);
    // Round the angle half up to units of 2^16 per turn, keep sixteen bits.
    z_round  = in_data.z + Z_W'(32768);
  end

  // Both half-up roundings fold into one add: 2^29 for the gain step, 128 << 30 for Q8.8.
  always_comb begin
    rnd_sum = {1'b0, m_prod_r} + (PROD_W + 1)'(39'h2020000000);
    spd_raw = rnd_sum[PROD_W:SHIFT];
    spd_sat = (spd_raw > RAW_W'({SPD_W{1'b1}})) ? {SPD_W{1'b1}} : spd_raw[SPD_W-1:0];
    if (!m_start_r) begin
      f_data_nxt = '0;
    end else begin
      f_data_nxt.drive_enable = 1'b1;
      f_data_nxt.heading      = m_zero_r ? '0 : m_head_r;
      if (spd_sat < cfg.dead_zone) begin
        f_data_nxt.speed = '0;
      end else if (spd_sat > cfg.speed_limit) begin
        f_data_nxt.speed = cfg.speed_limit;
      end else begin
        f_data_nxt.speed = spd_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
      f_valid_r <= 1'b0;
    end else begin
      if (m_ready) begin
        m_valid_r <= in_valid;
      end
      if (f_ready) begin
        f_valid_r <= m_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready && in_valid) begin
      m_prod_r  <= prod_nxt;
      m_head_r  <= z_round[31:16];
      m_zero_r  <= in_data.zero;
      m_start_r <= in_data.start;
    end
    if (f_ready && m_valid_r) begin
      f_data_r <= f_data_nxt;
    end
  end

  assign out_valid = f_valid_r;
  assign out_data  = f_data_r;

endmodule

/* hdl/formation_velocity_heading.sv */
// Top level of the formation velocity and heading block: ports, registers and pipeline.
`timescale 1ns / 1ps
// Each input beat carries the robot's own position, up to two neighbour positions (all
// signed Q8.8) and a start flag; each one yields exactly one command beat with drive
// enable, speed (Q8.8) and heading (binary angle, 32768 units equal pi). The block takes
// one beat in every clock cycle while the output is not stalled. The neighbour sum is
// registered first, then the scaled error vector folded into the right half plane; one
// register stage per vectoring micro-rotation follows, then the gain correction product
// is registered, and rounding, dead zone and clamp end in the output register.
// A stall on the output side fills bubbles first, so input beats are still taken while a
// finished command waits. Configuration writes are taken at any time, but should only be
// made while no beat is in flight; the register index follows the list neighbor_count,
// gain, offset_x1, offset_y1, offset_x2, offset_y2, dead_zone, speed_limit.
module formation_velocity_heading #(
  parameter int MAX_NEIGHBORS = 2,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write channel.
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fvh_pkg::IDX_W-1:0]   cfg_index,
  input  logic [fvh_pkg::CFG_W-1:0]   cfg_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // own_x [15:0], own_y [31:16], first_x [47:32], first_y [63:48],
  // second_x [79:64], second_y [95:80]
  input  logic [95:0] in_tdata,
  // start_flag [0]
  input  logic        in_tuser,
  // Output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // speed [14:0], heading [30:15]; bit 31 is zero padding.
  output logic [31:0] out_tdata,
  // drive_enable [0]
  output logic        out_tuser
);
  import fvh_pkg::*;

  cfg_t cfg_r;
  pos_t pos;

  logic vec_valid, vec_ready;
  rot_t vec_data;
  logic rot_valid, rot_ready;
  rot_t rot_data;
  cmd_t cmd;

  // Register file: every write is taken at once, unknown indexes cannot occur.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neighbor_count <= CNT_W'(1);
      cfg_r.gain           <= GAIN_W'(77);
      cfg_r.offset_x1      <= '0;
      cfg_r.offset_y1      <= '0;
      cfg_r.offset_x2      <= '0;
      cfg_r.offset_y2      <= '0;
      cfg_r.dead_zone      <= SPD_W'(51);
      cfg_r.speed_limit    <= SPD_W'(205);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NEIGHBOR_COUNT: cfg_r.neighbor_count <= cfg_data[CNT_W-1:0];
        REG_GAIN:           cfg_r.gain           <= cfg_data[GAIN_W-1:0];
        REG_OFFSET_X1:      cfg_r.offset_x1      <= cfg_data;
        REG_OFFSET_Y1:      cfg_r.offset_y1      <= cfg_data;
        REG_OFFSET_X2:      cfg_r.offset_x2      <= cfg_data;
        REG_OFFSET_Y2:      cfg_r.offset_y2      <= cfg_data;
        REG_DEAD_ZONE:      cfg_r.dead_zone      <= cfg_data[SPD_W-1:0];
        REG_SPEED_LIMIT:    cfg_r.speed_limit    <= cfg_data[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat.
  always_comb begin
    pos.own_x      = in_tdata[15:0];
    pos.own_y      = in_tdata[31:16];
    pos.first_x    = in_tdata[47:32];
    pos.first_y    = in_tdata[63:48];
    pos.second_x   = in_tdata[79:64];
    pos.second_y   = in_tdata[95:80];
    pos.start_flag = in_tuser;
  end

  // Error vector: sum over neighbours, scale by the gain, fold into the right half plane.
  fvh_vector #(
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_vector (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (pos),
    .out_valid (vec_valid),
    .out_ready (vec_ready),
    .out_data  (vec_data)
  );

  // Vectoring rotations drive y to zero and collect the angle in z.
  fvh_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_valid),
    .in_ready  (vec_ready),
    .in_data   (vec_data),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  // Magnitude correction and the speed shaping; the heading is rounded alongside.
  fvh_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_data   (rot_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (cmd)
  );

  assign out_tdata = {1'b0, cmd.heading, cmd.speed};
  assign out_tuser = cmd.drive_enable;

endmodule

/* tb/sv/formation_velocity_heading_test.sv */
// Self-checking testbench of the formation velocity and heading block.
`timescale 1ns / 1ps
// A directed table goes first: stop commands, the zero vector, each compass direction,
// the negative x axis, position and offset extremes, zero gain, neighbour counts of zero
// and above the maximum, and a dead zone above the speed limit. Random phases follow,
// each with fresh register settings and a mix of tight formations and full-range
// positions. Every command beat is compared field by field with the oldest prediction.
module formation_velocity_heading_test;
  import fvh_pkg::*;

  localparam int NB_MAX        = 2;
  localparam int ROT_STAGES    = 16;
  localparam int LATENCY       = ROT_STAGES + 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 50;
  localparam int HOLD_CYCLES   = 300;
  localparam int REPORT_CAP    = 20;

  // Micro-rotation angles in units where 2^32 is a full turn.
  localparam longint ATAN_UNITS [ROT_STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };
  localparam longint HALF_TURN  = 64'sd2147483648;
  localparam longint GAIN_RECIP = 64'sd652032874;

  // Commands that can be read straight off the behaviour.
  localparam cmd_t CMD_STOP       = '0;
  localparam cmd_t CMD_STAND_STILL = cmd_t'{1'b1, 15'd0, 16'd0};

  typedef enum logic { ROW_WRITE, ROW_BEAT } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    reg_idx_t         reg_sel;
    logic [CFG_W-1:0] value;
    pos_t             beat;
    logic             typed;
    cmd_t             want;
  } row_t;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_valid  = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]   cfg_data   = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [95:0]        in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [31:0]        out_tdata;
  logic               out_tuser;

  // Register copy kept by the predictor; starts at the reset values.
  cfg_t steer_cfg = '{neighbor_count: 2'd1, gain: 8'd77, offset_x1: '0, offset_y1: '0,
                      offset_x2: '0, offset_y2: '0, dead_zone: 15'd51, speed_limit: 15'd205};

  cmd_t pending_cmds [$];

  int  mismatches  = 0;
  int  beats_in    = 0;
  int  beats_out   = 0;
  int  stop_beats  = 0;
  int  cfg_beats   = 0;
  int  cycle_count = 0;

  // Idling control shared between the sender, the receiver and the stimulus.
  bit  steady_tx  = 1'b0;
  bit  steady_rx  = 1'b0;
  bit  hold_arm   = 1'b0;
  bit  hold_done  = 1'b0;
  bit  rx_hold    = 1'b0;

  formation_velocity_heading #(
    .MAX_NEIGHBORS(NB_MAX),
    .CORDIC_STAGES(ROT_STAGES)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count == CYCLE_LIMIT);
    $display("run stopped: no completion within %0d cycles", CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // Works out the command for one position beat under the current register copy.
  function automatic cmd_t steer_command(input pos_t b);
    longint own_x, own_y, sum_x, sum_y, vx, vy, ang, swap, mag, spd, turn;
    int     used;
    cmd_t   c;
    c = CMD_STOP;
    if (!b.start_flag) return c;
    used  = (steer_cfg.neighbor_count > NB_MAX) ? NB_MAX : int'(steer_cfg.neighbor_count);
    own_x = longint'($signed(b.own_x));
    own_y = longint'($signed(b.own_y));
    sum_x = 0;
    sum_y = 0;
    if (used >= 1) begin
      sum_x += longint'($signed(b.first_x)) - own_x + longint'($signed(steer_cfg.offset_x1));
      sum_y += longint'($signed(b.first_y)) - own_y + longint'($signed(steer_cfg.offset_y1));
    end
    if (used >= 2) begin
      sum_x += longint'($signed(b.second_x)) - own_x + longint'($signed(steer_cfg.offset_x2));
      sum_y += longint'($signed(b.second_y)) - own_y + longint'($signed(steer_cfg.offset_y2));
    end
    // Scale to Q8.16 before the vectoring rotations.
    vx  = sum_x * longint'(steer_cfg.gain);
    vy  = sum_y * longint'(steer_cfg.gain);
    ang = 0;
    // Left half plane: pre-rotate by half a turn so the rotations converge.
    if (vx < 0) begin
      ang = (vy >= 0) ? HALF_TURN : -HALF_TURN;
      vx  = -vx;
      vy  = -vy;
    end
    for (int i = 0; i < ROT_STAGES; i++) begin
      if (vy > 0) begin
        swap = vx + (vy >>> i);
        vy   = vy - (vx >>> i);
        vx   = swap;
        ang += ATAN_UNITS[i];
      end else begin
        swap = vx - (vy >>> i);
        vy   = vy + (vx >>> i);
        vx   = swap;
        ang -= ATAN_UNITS[i];
      end
    end
    if (vx < 0) vx = 0;
    mag = (vx * GAIN_RECIP + (longint'(1) <<< 29)) >>> 30;
    spd = (mag + 128) >>> 8;
    if (spd > 32767) spd = 32767;
    // The dead zone is tested before the clamp, even when it lies above the limit.
    if (spd < longint'(steer_cfg.dead_zone)) spd = 0;
    else if (spd > longint'(steer_cfg.speed_limit)) spd = longint'(steer_cfg.speed_limit);
    if ((sum_x == 0 && sum_y == 0) || steer_cfg.gain == 0) ang = 0;
    turn = ((ang + (longint'(1) <<< 40) + 32768) >>> 16) - (longint'(1) <<< 24);
    c.drive_enable = 1'b1;
    c.speed        = spd[SPD_W-1:0];
    c.heading      = turn[HEAD_W-1:0];
    return c;
  endfunction

  function automatic pos_t place(input logic [15:0] ox, oy, fx, fy, sx, sy, input logic st);
    pos_t b;
    b.own_x      = ox;
    b.own_y      = oy;
    b.first_x    = fx;
    b.first_y    = fy;
    b.second_x   = sx;
    b.second_y   = sy;
    b.start_flag = st;
    return b;
  endfunction

  function automatic row_t write_row(input reg_idx_t r, input logic [CFG_W-1:0] v);
    row_t row;
    row.kind    = ROW_WRITE;
    row.reg_sel = r;
    row.value   = v;
    row.beat    = '0;
    row.typed   = 1'b0;
    row.want    = CMD_STOP;
    return row;
  endfunction

  // A beat row; typed rows carry their expected command, the others use the predictor.
  function automatic row_t beat_row(input pos_t b, input logic typed, input cmd_t want);
    row_t row;
    row.kind    = ROW_BEAT;
    row.reg_sel = REG_NEIGHBOR_COUNT;
    row.value   = '0;
    row.beat    = b;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in a steady stretch.
  function automatic int idle_cycles(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatches < REPORT_CAP)
      $display("mismatch on %s at command %0d: got %0d, expected %0d",
               what, beats_out, got, want);
    mismatches++;
  endtask

  // Register writes are made only with nothing in flight: every beat gives exactly one
  // command, so an empty store of pending commands means the pipeline is empty.
  task automatic write_reg(input reg_idx_t r, input logic [CFG_W-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_NEIGHBOR_COUNT: steer_cfg.neighbor_count = v[CNT_W-1:0];
      REG_GAIN:           steer_cfg.gain           = v[GAIN_W-1:0];
      REG_OFFSET_X1:      steer_cfg.offset_x1      = v;
      REG_OFFSET_Y1:      steer_cfg.offset_y1      = v;
      REG_OFFSET_X2:      steer_cfg.offset_x2      = v;
      REG_OFFSET_Y2:      steer_cfg.offset_y2      = v;
      REG_DEAD_ZONE:      steer_cfg.dead_zone      = v[SPD_W-1:0];
      REG_SPEED_LIMIT:    steer_cfg.speed_limit    = v[SPD_W-1:0];
      default: ;
    endcase
    cfg_beats++;
  endtask

  // Offers one position beat and returns at the edge that accepts it, so that the next
  // beat can follow in the same time step without valid dropping in between.
  task automatic send_beat(input pos_t b, input logic typed, input cmd_t want);
    int gap;
    gap = rx_hold ? 0 : idle_cycles(steady_tx);
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b.second_y, b.second_x, b.first_y, b.first_x, b.own_y, b.own_x};
    in_tuser  <= b.start_flag;
    do @(posedge clk); while (!in_tready);
    pending_cmds.push_back(typed ? want : steer_command(b));
    beats_in++;
    if (!b.start_flag) stop_beats++;
  endtask

  // Receiver: random stalls and ready runs, plus one long hold-off while the sender keeps
  // offering beats back to back, so that the pipeline fills and input ready drops.
  initial begin : receiver
    int stall;
    int run;
    wait (rst_n);
    forever begin
      if (hold_arm && !hold_done) begin
        rx_hold = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold   = 1'b0;
        hold_done = 1'b1;
      end else begin
        stall = idle_cycles(steady_rx);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end

  // Output checker: values seen at the edge are those from before it, as all drivers use
  // nonblocking assignments.
  always @(posedge clk) begin
    cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (pending_cmds.size() == 0) begin
        report_mismatch("unexpected command beat", out_tdata, 0);
      end else begin
        want = pending_cmds.pop_front();
        if (out_tuser !== want.drive_enable)
          report_mismatch("drive_enable", out_tuser, want.drive_enable);
        if (out_tdata[14:0] !== want.speed)
          report_mismatch("speed", out_tdata[14:0], want.speed);
        if (out_tdata[30:15] !== want.heading)
          report_mismatch("heading", $signed(out_tdata[30:15]), $signed(want.heading));
        if (out_tdata[31] !== 1'b0)
          report_mismatch("padding bit", out_tdata[31], 0);
      end
    end
  end

  initial begin : stimulus
    row_t             plan [$];
    pos_t             b;
    int               cnt;
    int               mode;
    int               span;
    bit               near;
    logic [GAIN_W-1:0] g;
    logic [CFG_W-1:0] ox1, oy1, ox2, oy2, dz, lim;

    // Directed table, first under the reset settings.
    plan.push_back(beat_row(place(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                                  1'b0), 1'b1, CMD_STOP));
    plan.push_back(beat_row(place(0, 0, 0, 0, 0, 0, 1'b1), 1'b1, CMD_STAND_STILL));
    plan.push_back(beat_row(place(0, 0, 16'h0100, 0, 0, 0, 1'b1), 1'b0, CMD_STOP));
    // Straight along the negative x axis: the heading of half a turn wraps.
    plan.push_back(beat_row(place(0, 0, 16'hFF00, 0, 0, 0, 1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(0, 0, 0, 16'h0100, 0, 0, 1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(0, 0, 0, 16'hFF00, 0, 0, 1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                  1'b1), 1'b0, CMD_STOP));
    // Zero gain leaves nothing to drive towards.
    plan.push_back(write_row(REG_GAIN, 16'h0000));
    plan.push_back(beat_row(place(16'h8000, 0, 16'h7FFF, 0, 0, 0, 1'b1), 1'b1, CMD_STAND_STILL));
    // Full gain, both neighbours, no dead zone and the widest limit: saturation.
    plan.push_back(write_row(REG_NEIGHBOR_COUNT, 16'hFFFE));
    plan.push_back(write_row(REG_GAIN, 16'hFFFF));
    plan.push_back(write_row(REG_DEAD_ZONE, 16'h0000));
    plan.push_back(write_row(REG_SPEED_LIMIT, 16'hFFFF));
    plan.push_back(beat_row(place(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(16'h7FFF, 0, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
                                  1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(16'h0123, 16'hFEDC, 16'h0456, 16'hFF00, 16'h0200, 16'h0300,
                                  1'b1), 1'b0, CMD_STOP));
    // No neighbour summed gives the zero vector.
    plan.push_back(write_row(REG_NEIGHBOR_COUNT, 16'h0000));
    plan.push_back(beat_row(place(16'h1234, 16'h8765, 16'h7FFF, 16'h8000, 16'h0100, 16'hF000,
                                  1'b1), 1'b1, CMD_STAND_STILL));
    // A count above the maximum behaves as the maximum.
    plan.push_back(write_row(REG_NEIGHBOR_COUNT, 16'hFFFF));
    plan.push_back(beat_row(place(16'h1234, 16'h8765, 16'h7FFF, 16'h8000, 16'h0100, 16'hF000,
                                  1'b1), 1'b0, CMD_STOP));
    plan.push_back(write_row(REG_OFFSET_X1, 16'h7FFF));
    plan.push_back(write_row(REG_OFFSET_Y1, 16'h8000));
    plan.push_back(write_row(REG_OFFSET_X2, 16'h8000));
    plan.push_back(write_row(REG_OFFSET_Y2, 16'h7FFF));
    plan.push_back(beat_row(place(0, 0, 0, 0, 0, 0, 1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                  1'b1), 1'b0, CMD_STOP));
    // Dead zone above the limit: a fast vector clamps, a slow one stops.
    plan.push_back(write_row(REG_DEAD_ZONE, 16'd1000));
    plan.push_back(write_row(REG_SPEED_LIMIT, 16'd100));
    plan.push_back(beat_row(place(16'hC000, 0, 16'h4000, 0, 16'h4000, 0, 1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(0, 0, 16'h0010, 0, 0, 0, 1'b1), 1'b0, CMD_STOP));
    plan.push_back(write_row(REG_DEAD_ZONE, 16'hFFFF));
    plan.push_back(write_row(REG_SPEED_LIMIT, 16'h7FFF));
    plan.push_back(beat_row(place(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                  1'b1), 1'b0, CMD_STOP));
    plan.push_back(beat_row(place(0, 0, 0, 0, 0, 0, 1'b0), 1'b1, CMD_STOP));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) write_reg(plan[k].reg_sel, plan[k].value);
      else send_beat(plan[k].beat, plan[k].typed, plan[k].want);
    end

    // Random phases: every register is rewritten, then a burst of position beats.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      steady_tx = (ph % 3 == 1);
      steady_rx = (ph % 3 == 2);
      case (ph)
        0: begin
          // Widest settings.
          cnt = 2; g = 8'hFF; dz = 16'h0000; lim = 16'h7FFF;
          ox1 = 16'h7FFF; oy1 = 16'h8000; ox2 = 16'h8000; oy2 = 16'h7FFF;
        end
        1: begin
          // Narrowest settings: a zero limit makes every moving command zero speed.
          cnt = 1; g = 8'h01; dz = 16'h0000; lim = 16'h0000;
          ox1 = 16'h0000; oy1 = 16'h0000; ox2 = 16'h0000; oy2 = 16'h0000;
        end
        default: begin
          mode = $urandom_range(0, 9);
          cnt  = (mode == 0) ? 0 : (mode == 1) ? 3 : (mode < 5) ? 1 : 2;
          mode = $urandom_range(0, 9);
          g    = (mode == 0) ? 8'h00 : (mode == 1) ? 8'hFF : 8'($urandom);
          mode = $urandom_range(0, 3);
          // Rendezvous, small formation, full-range formation or consensus on a target.
          ox1  = (mode == 0) ? 16'h0000 : (mode == 2) ? 16'($urandom) :
                 16'($urandom_range(0, 1024)) - 16'd512;
          oy1  = (mode == 0) ? 16'h0000 : (mode == 2) ? 16'($urandom) :
                 16'($urandom_range(0, 1024)) - 16'd512;
          ox2  = (mode == 3) ? ox1 : (mode == 0) ? 16'h0000 : 16'($urandom);
          oy2  = (mode == 3) ? oy1 : (mode == 0) ? 16'h0000 : 16'($urandom);
          mode = $urandom_range(0, 9);
          dz   = (mode == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
          mode = $urandom_range(0, 9);
          lim  = (mode == 0) ? 16'($urandom) : (mode == 1) ? 16'h7FFF :
                 16'($urandom_range(100, 3000));
        end
      endcase
      // Upper bits beyond each register's width are random and must be dropped.
      write_reg(REG_NEIGHBOR_COUNT, {14'($urandom), 2'(cnt)});
      write_reg(REG_GAIN, {8'($urandom), g});
      write_reg(REG_OFFSET_X1, ox1);
      write_reg(REG_OFFSET_Y1, oy1);
      write_reg(REG_OFFSET_X2, ox2);
      write_reg(REG_OFFSET_Y2, oy2);
      write_reg(REG_DEAD_ZONE, dz);
      write_reg(REG_SPEED_LIMIT, lim);
      if (ph == 2) begin
        // Start the burst only once the receiver holds off, so that it fills the pipeline.
        hold_arm = 1'b1;
        cfg_valid <= 1'b0;
        wait (rx_hold);
      end
      repeat (PHASE_ITEMS) begin
        // Mostly neighbours close to the robot, so speeds land around the dead zone and
        // the limit; the rest anywhere in the position range.
        near       = ($urandom_range(0, 3) != 0);
        span       = $urandom_range(1, 1024);
        b.own_x    = 16'($urandom);
        b.own_y    = 16'($urandom);
        b.first_x  = near ? b.own_x + 16'($urandom_range(0, 2 * span)) - 16'(span)
                          : 16'($urandom);
        b.first_y  = near ? b.own_y + 16'($urandom_range(0, 2 * span)) - 16'(span)
                          : 16'($urandom);
        b.second_x = near ? b.own_x + 16'($urandom_range(0, 2 * span)) - 16'(span)
                          : 16'($urandom);
        b.second_y = near ? b.own_y + 16'($urandom_range(0, 2 * span)) - 16'(span)
                          : 16'($urandom);
        b.start_flag = ($urandom_range(0, 9) != 0);
        send_beat(b, 1'b0, CMD_STOP);
      end
    end
    in_tvalid <= 1'b0;
    steady_rx = 1'b0;

    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("covered %0d position beats (%0d stop requests) across %0d register writes",
             beats_in, stop_beats, cfg_beats);
    $display("%0d command beats checked, with one %0d-cycle receiver hold-off",
             beats_out, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/fvh_pkg.sv
hdl/fvh_vector.sv
hdl/fvh_cordic.sv
hdl/fvh_scale.sv
hdl/formation_velocity_heading.sv
tb/sv/formation_velocity_heading_test.sv
